[src/depth_patch_decimator_top_assert.svh]
// Assertion macros shared by the decimator RTL.
// Each macro expands to one labeled concurrent assertion on clk, disabled in reset.
`ifndef DEPTH_PATCH_DECIMATOR_TOP_ASSERT_SVH
`define DEPTH_PATCH_DECIMATOR_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define DPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be true outside reset.
`define DPD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[src/dpd_pkg.sv]
// ----------------------------------------------------------------------------
// dpd_pkg
// Types and constants shared by the depth patch decimator files.
// ----------------------------------------------------------------------------
package dpd_pkg;

  localparam int DEPTH_W   = 16;
  localparam int SUM_W     = 22;
  localparam int CNT_W     = 7;
  localparam int MAX_KEPT  = 9;
  localparam int COUNT_MAX = 127;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [2:0] REG_SCALE        = 3'd0;
  localparam logic [2:0] REG_SOURCE_WIDTH = 3'd1;
  localparam logic [2:0] REG_OUT_WIDTH    = 3'd2;
  localparam logic [2:0] REG_PADDED_WIDTH = 3'd3;
  localparam logic [2:0] REG_OUT_HEIGHT   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOOKUP,
    ST_UPDATE,
    ST_MEAN,
    ST_MREAD,
    ST_MSEL,
    ST_EMIT
  } state_t;

endpackage

[src/dpd_ram.sv]
// ----------------------------------------------------------------------------
// dpd_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/depth_patch_decimator_top.sv]
// ----------------------------------------------------------------------------
// depth_patch_decimator_top
// Reduces each scale x scale patch of a depth stream to its lower median
// (scale 2 or 3) or truncated mean of the nonzero pixels, with row padding.
// ----------------------------------------------------------------------------
//  Channel   Kind    Payload
//  s_axis    in      tdata[15:0] depth, tuser[0] frame_start
//  m_axis    out     tdata[15:0] value, tlast row_end, tuser[0] last
//  apb       config  scale, source_width, out_width, padded_width, out_height
//
// One pixel at a time: the shared shift-subtract divider finds the patch
// column, then the column store is read and written back. A pixel that
// completes a patch adds n kept-value reads plus up to n rank steps for the
// median, or 22 divider steps for the mean, then its results wait on the
// receiver. Reset is synchronous; the stores need no clearing pass.
// A stalled output holds the block; no pixel is taken while a result waits.
module depth_patch_decimator_top #(
  parameter int MAX_OUT_COLUMNS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] depth
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] value
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser,   // [0] last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dpd_pkg::*;

  localparam int AW = $clog2(MAX_OUT_COLUMNS);
  localparam int KDEPTH = MAX_OUT_COLUMNS * MAX_KEPT;
  localparam int KW = $clog2(KDEPTH);
  localparam int PW = (AW > 11) ? AW : 11;

  // Configuration registers.
  logic [3:0]  scale;
  logic [11:0] source_width;
  logic [11:0] out_width;
  logic [11:0] padded_width;
  logic [11:0] out_height;

  // Position in the frame.
  logic [10:0] src_col;
  logic [2:0]  row_in_band;
  logic [11:0] band_idx;

  state_t state, state_next;

  logic [DEPTH_W-1:0] depth_q;

  // Shared divider.
  logic [SUM_W-1:0] div_num;
  logic [CNT_W-1:0] div_den;
  logic [CNT_W-1:0] div_rem;
  logic [SUM_W-1:0] div_quo;
  logic [4:0]       div_step;
  logic [4:0]       div_steps;
  logic [CNT_W:0]   div_trial;
  logic             div_ge;
  logic             div_done;

  // Patch bookkeeping.
  logic             is_end_q;
  logic [1:0]       pad_q;
  logic [1:0]       pad_left;
  logic [3:0]       kn;
  logic [3:0]       mi;
  logic [3:0]       ci;
  logic             rd_pend;
  logic [3:0]       rd_idx;
  logic [KW-1:0]    kbase_q;
  logic [DEPTH_W-1:0] vals [MAX_KEPT];

  logic [DEPTH_W-1:0] out_value;
  logic               out_row_end;
  logic               out_last;

  // Effective register values.
  logic [3:0]  s_eff;
  logic [11:0] w_eff;
  always_comb begin
    if (scale == 4'd0) s_eff = 4'd1;
    else if (scale > 4'd8) s_eff = 4'd8;
    else s_eff = scale;
    if (source_width == 12'd0) w_eff = 12'd1;
    else if (source_width > 12'd2048) w_eff = 12'd2048;
    else w_eff = source_width;
  end

  // Configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= 4'd2;
      source_width <= 12'd640;
      out_width    <= 12'd320;
      padded_width <= 12'd320;
      out_height   <= 12'd240;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_SCALE:        scale        <= pwdata[3:0];
        REG_SOURCE_WIDTH: source_width <= pwdata[11:0];
        REG_OUT_WIDTH:    out_width    <= pwdata[11:0];
        REG_PADDED_WIDTH: padded_width <= pwdata[11:0];
        REG_OUT_HEIGHT:   out_height   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SCALE:        prdata = {28'd0, scale};
      REG_SOURCE_WIDTH: prdata = {20'd0, source_width};
      REG_OUT_WIDTH:    prdata = {20'd0, out_width};
      REG_PADDED_WIDTH: prdata = {20'd0, padded_width};
      REG_OUT_HEIGHT:   prdata = {20'd0, out_height};
      default:          prdata = 32'd0;
    endcase
  end

  // Column state memory: {count, sum} per patch column.
  logic                   col_we;
  logic [AW-1:0]          col_addr;
  logic [CNT_W+SUM_W-1:0] col_wdata;
  logic [CNT_W+SUM_W-1:0] col_rdata;

  dpd_ram #(.WIDTH(CNT_W + SUM_W), .DEPTH(MAX_OUT_COLUMNS)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_addr),
    .wdata (col_wdata),
    .raddr (col_addr),
    .rdata (col_rdata)
  );

  // Kept valid values, MAX_KEPT slots per patch column.
  logic               kept_we;
  logic [KW-1:0]      kept_waddr;
  logic [KW-1:0]      kept_raddr;
  logic [DEPTH_W-1:0] kept_rdata;

  dpd_ram #(.WIDTH(DEPTH_W), .DEPTH(KDEPTH)) u_kept_ram (
    .clk   (clk),
    .we    (kept_we),
    .waddr (kept_waddr),
    .wdata (depth_q),
    .raddr (kept_raddr),
    .rdata (kept_rdata)
  );

  // Accept-time position.
  logic        in_accept;
  logic [10:0] col_start;
  assign in_accept = s_axis_tvalid && s_axis_tready;
  always_comb begin
    col_start = s_axis_tuser[0] ? 11'd0 : src_col;
    if ({1'b0, col_start} >= w_eff) col_start = 11'd0;
  end

  // Patch column and sub-column come out of the divider.
  logic [PW-1:0]  p_wide;
  logic [3:0]     sub;
  logic           p_ok;
  logic [KW-1:0]  kbase;
  assign p_wide = PW'(div_quo[10:0]);
  assign sub    = div_rem[3:0];
  assign col_addr = p_wide[AW-1:0];
  assign p_ok = ({1'b0, p_wide} < (PW + 1)'(out_width)) &&
                ({1'b0, p_wide} < (PW + 1)'(MAX_OUT_COLUMNS));
  assign kbase = (KW'(p_wide) << 3) + KW'(p_wide);

  // Read-modify-write of the column state. The read is issued in the lookup
  // cycle and written back in the following update cycle; one pixel is in
  // flight at a time, so a later read never sees a stale entry.
  logic           clear_col;
  logic [CNT_W-1:0] cnt_old, cnt_new;
  logic [SUM_W-1:0] sum_old, sum_new;
  logic           fin;
  logic [3:0]     row_p1;
  logic           is_end;
  logic [1:0]     pad;
  logic [11:0]    pad_diff;
  always_comb begin
    clear_col = (row_in_band == 3'd0) && (sub == 4'd0);
    cnt_old = clear_col ? '0 : col_rdata[CNT_W+SUM_W-1:SUM_W];
    sum_old = clear_col ? '0 : col_rdata[SUM_W-1:0];
    cnt_new = cnt_old;
    sum_new = sum_old;
    if (depth_q != '0) begin
      sum_new = sum_old + SUM_W'(depth_q);
      if (cnt_old < CNT_W'(COUNT_MAX)) cnt_new = cnt_old + 1'b1;
    end
    row_p1 = {1'b0, row_in_band} + 4'd1;
    fin = (row_p1 >= s_eff) && (sub == s_eff - 4'd1) && (band_idx < out_height);
    is_end = (12'(p_wide) + 12'd1 == out_width);
    pad_diff = padded_width - out_width;
    pad = 2'd0;
    if (is_end && (padded_width > out_width)) begin
      pad = (pad_diff > 12'd3) ? 2'd3 : pad_diff[1:0];
    end
  end

  assign col_wdata  = {cnt_new, sum_new};
  assign kept_waddr = kbase + KW'(cnt_old);
  // The divider is reused after the update, so the patch base is held.
  assign kept_raddr = kbase_q + KW'(mi);

  // Divider step.
  assign div_trial = {div_rem, div_num[SUM_W-1]};
  assign div_ge    = div_trial >= {1'b0, div_den};
  assign div_done  = (div_step == div_steps - 5'd1);

  // Rank of the current median candidate.
  logic [3:0]         rank;
  logic [DEPTH_W-1:0] cand;
  logic [3:0]         target;
  logic               found;
  always_comb begin
    cand = vals[ci];
    rank = 4'd0;
    for (int j = 0; j < MAX_KEPT; j++) begin
      if ((4'(j) < kn) && ((vals[j] < cand) || ((vals[j] == cand) && (4'(j) < ci)))) begin
        rank = rank + 4'd1;
      end
    end
    target = (kn - 4'd1) >> 1;
    found  = (rank == target);
  end

  logic is_median;
  assign is_median = (s_eff == 4'd2) || (s_eff == 4'd3);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_accept) state_next = ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = p_ok ? ST_UPDATE : ST_IDLE;
      ST_UPDATE: begin
        if (!fin) state_next = ST_IDLE;
        else if (cnt_new == '0) state_next = ST_EMIT;
        else if (is_median) state_next = ST_MREAD;
        else state_next = ST_MEAN;
      end
      ST_MEAN:   if (div_done) state_next = ST_EMIT;
      ST_MREAD:  if (mi == kn) state_next = ST_MSEL;
      ST_MSEL:   if (found) state_next = ST_EMIT;
      ST_EMIT:   if (m_axis_tready && pad_left == 2'd0) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  logic advance;
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    col_we  = 1'b0;
    kept_we = 1'b0;
    advance = 1'b0;
    case (state)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_LOOKUP: advance = !p_ok;
      ST_UPDATE: begin
        col_we  = 1'b1;
        kept_we = (depth_q != '0) && (cnt_old < CNT_W'(MAX_KEPT));
        advance = !fin;
      end
      ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        advance = m_axis_tready && (pad_left == 2'd0);
      end
      default: ;
    endcase
  end

  assign m_axis_tdata    = out_value;
  assign m_axis_tlast    = out_row_end;
  assign m_axis_tuser[0] = out_last;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Position counters.
  logic [3:0] row_adv;
  assign row_adv = {1'b0, row_in_band} + 4'd1;
  always_ff @(posedge clk) begin
    if (rst) begin
      src_col     <= '0;
      row_in_band <= '0;
      band_idx    <= '0;
    end else if (in_accept) begin
      src_col <= col_start;
      if (s_axis_tuser[0]) begin
        row_in_band <= '0;
        band_idx    <= '0;
      end
    end else if (advance) begin
      if ({1'b0, src_col} + 12'd1 >= w_eff) begin
        src_col <= '0;
        if (row_adv >= s_eff) begin
          row_in_band <= '0;
          if (band_idx != 12'd4095) band_idx <= band_idx + 12'd1;
        end else begin
          row_in_band <= row_adv[2:0];
        end
      end else begin
        src_col <= src_col + 11'd1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == ST_MREAD) && (mi < kn);
    end
  end

  logic out_load;
  logic [DEPTH_W-1:0] out_load_val;
  always_comb begin
    out_load = 1'b0;
    out_load_val = '0;
    case (state)
      ST_UPDATE: out_load = fin && (cnt_new == '0);
      ST_MEAN: begin
        out_load = div_done;
        out_load_val = {div_quo[DEPTH_W-2:0], div_ge};
      end
      ST_MSEL: begin
        out_load = found;
        out_load_val = cand;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      depth_q   <= s_axis_tdata;
      div_num   <= {col_start, 11'd0};
      div_den   <= CNT_W'(s_eff);
      div_rem   <= '0;
      div_quo   <= '0;
      div_step  <= '0;
      div_steps <= 5'd11;
    end else if (state == ST_DIV || state == ST_MEAN) begin
      div_num  <= div_num << 1;
      div_rem  <= div_ge ? CNT_W'(div_trial - {1'b0, div_den}) : div_trial[CNT_W-1:0];
      div_quo  <= {div_quo[SUM_W-2:0], div_ge};
      div_step <= div_step + 5'd1;
    end else if (state == ST_UPDATE) begin
      is_end_q <= is_end;
      pad_q    <= pad;
      kbase_q  <= kbase;
      kn       <= (cnt_new < CNT_W'(MAX_KEPT)) ? cnt_new[3:0] : 4'(MAX_KEPT);
      mi       <= '0;
      ci       <= '0;
      // The mean reuses the divider; the column index is no longer needed.
      div_num   <= sum_new;
      div_den   <= cnt_new;
      div_rem   <= '0;
      div_quo   <= '0;
      div_step  <= '0;
      div_steps <= 5'(SUM_W);
    end else if (state == ST_MREAD) begin
      if (mi < kn) mi <= mi + 4'd1;
      rd_idx <= mi;
    end else if (state == ST_MSEL) begin
      ci <= ci + 4'd1;
    end
    if (rd_pend) vals[rd_idx] <= kept_rdata;

    if (out_load) begin
      out_value <= out_load_val;
      if (state == ST_UPDATE) begin
        out_row_end <= is_end && (pad == 2'd0);
        out_last    <= (pad == 2'd0);
        pad_left    <= pad;
      end else begin
        out_row_end <= is_end_q && (pad_q == 2'd0);
        out_last    <= (pad_q == 2'd0);
        pad_left    <= pad_q;
      end
    end else if (state == ST_EMIT && m_axis_tready && pad_left != 2'd0) begin
      // Padding zeros follow the last patch of the row.
      out_value   <= '0;
      out_row_end <= (pad_left == 2'd1);
      out_last    <= (pad_left == 2'd1);
      pad_left    <= pad_left - 2'd1;
    end
  end

  `include "depth_patch_decimator_top_assert.svh"

  `DPD_NEVER(a_one_at_a_time, s_axis_tready && m_axis_tvalid, "input taken during output")
  `DPD_ASSERT(a_row_end_last, m_axis_tvalid |-> (!m_axis_tlast || m_axis_tuser[0]), "row end not last")
  `DPD_ASSERT(a_pad_follows, (m_axis_tvalid && m_axis_tready && !m_axis_tuser[0]) |=> (m_axis_tvalid && m_axis_tdata == 16'd0), "pad missing")
  `DPD_ASSERT(a_accept_div, (s_axis_tvalid && s_axis_tready) |=> (state == ST_DIV), "divider not started")

endmodule

[tb/dpd_checker.sv]
// ----------------------------------------------------------------------------
// dpd_checker
// Watches the pixel, result and register channels of the depth patch
// decimator, predicts each result from the accepted pixels and compares.
// ----------------------------------------------------------------------------
module dpd_checker
  import dpd_pkg::*;
#(
  parameter int MAX_OUT_COLUMNS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] depth
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [15:0] value
  input  logic        m_axis_tlast,
  input  logic [0:0]  m_axis_tuser,   // [0] last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] value;
    logic        row_end;
    logic        last;
  } patch_result_t;

  patch_result_t expected_q[$];

  logic [15:0] kept[MAX_OUT_COLUMNS][MAX_KEPT];
  logic [21:0] patch_sum[MAX_OUT_COLUMNS];
  logic [6:0]  patch_count[MAX_OUT_COLUMNS];
  int unsigned col_pos, row_pos, band;

  logic [3:0]  cfg_scale;
  logic [11:0] cfg_source_width, cfg_out_width, cfg_padded_width, cfg_out_height;

  function automatic logic [15:0] lower_median(int unsigned p, int unsigned n);
    logic [15:0] v[MAX_KEPT];
    logic [15:0] x;
    int unsigned j;
    for (int unsigned i = 0; i < n; i++) begin
      x = kept[p][i];
      j = i;
      while (j > 0 && v[j-1] > x) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = x;
    end
    return v[(n - 1) / 2];
  endfunction

  task automatic take_pixel(input logic [15:0] depth, input logic frame_start);
    int unsigned s, w, col, p, sub, cnt, padn, n;
    patch_result_t res[4];
    s = (cfg_scale == 0) ? 1 : ((cfg_scale > 8) ? 8 : cfg_scale);
    w = (cfg_source_width == 0) ? 1 : ((cfg_source_width > 2048) ? 2048 : cfg_source_width);
    if (frame_start) begin
      col_pos = 0;
      row_pos = 0;
      band = 0;
    end
    if (col_pos >= w) col_pos = 0;
    col = col_pos;
    p = col / s;
    sub = col % s;
    if (p < cfg_out_width && p < MAX_OUT_COLUMNS) begin
      if (row_pos == 0 && sub == 0) begin
        patch_sum[p] = '0;
        patch_count[p] = '0;
      end
      if (depth != 0) begin
        if (patch_count[p] < MAX_KEPT) kept[p][patch_count[p]] = depth;
        patch_sum[p] = patch_sum[p] + 22'(depth);
        if (patch_count[p] < COUNT_MAX) patch_count[p]++;
      end
      if (row_pos + 1 >= s && sub == s - 1 && band < cfg_out_height) begin
        cnt = patch_count[p];
        res[0] = '0;
        if (cnt != 0) begin
          if (s == 2 || s == 3)
            res[0].value = lower_median(p, (cnt < MAX_KEPT) ? cnt : MAX_KEPT);
          else
            res[0].value = 16'(patch_sum[p] / cnt);
        end
        n = 1;
        if (p + 1 == cfg_out_width) begin
          padn = 0;
          if (cfg_padded_width > cfg_out_width) begin
            padn = cfg_padded_width - cfg_out_width;
            if (padn > 3) padn = 3;
          end
          for (int unsigned k = 0; k < padn; k++) begin
            res[n] = '0;
            n++;
          end
          res[n-1].row_end = 1'b1;
        end
        res[n-1].last = 1'b1;
        for (int unsigned k = 0; k < n; k++) expected_q.push_back(res[k]);
      end
    end
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= s) begin
        row_pos = 0;
        if (band < 4095) band++;
      end
    end else begin
      col_pos = col + 1;
    end
  endtask

  always @(posedge clk) begin
    patch_result_t want, got;
    if (rst) begin
      expected_q.delete();
      col_pos = 0;
      row_pos = 0;
      band = 0;
      cfg_scale = 4'd2;
      cfg_source_width = 12'd640;
      cfg_out_width = 12'd320;
      cfg_padded_width = 12'd320;
      cfg_out_height = 12'd240;
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_SCALE:        cfg_scale = pwdata[3:0];
          REG_SOURCE_WIDTH: cfg_source_width = pwdata[11:0];
          REG_OUT_WIDTH:    cfg_out_width = pwdata[11:0];
          REG_PADDED_WIDTH: cfg_padded_width = pwdata[11:0];
          REG_OUT_HEIGHT:   cfg_out_height = pwdata[11:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) take_pixel(s_axis_tdata, s_axis_tuser[0]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.value = m_axis_tdata;
        got.row_end = m_axis_tlast;
        got.last = m_axis_tuser[0];
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result value=%h row_end=%b last=%b",
                     $realtime, got.value, got.row_end, got.last);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== got) begin
            if (errors < 10)
              $display("%0t: mismatch exp value=%h row_end=%b last=%b, got %h %b %b",
                       $realtime, want.value, want.row_end, want.last,
                       got.value, got.row_end, got.last);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

[tb/tb_depth_patch_decimator_top.sv]
// ----------------------------------------------------------------------------
// tb_depth_patch_decimator_top
// Runs the decimator through a directed frame and a series of randomized
// frames under several register settings and handshake stall patterns.
// ----------------------------------------------------------------------------
module tb_depth_patch_decimator_top;
  import dpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors, pending, results_seen;
  int pixels_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  depth_patch_decimator_top u_dut (.*);

  dpd_checker u_checker (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending, .results_seen
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_depth_patch_decimator_top failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_pixel(input logic [15:0] depth, input logic frame_start);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= depth;
    s_axis_tuser <= frame_start;
    @(posedge clk iff (s_axis_tvalid && s_axis_tready));
    pixels_sent++;
  endtask

  function automatic logic [15:0] random_depth(input bit bias_high);
    int unsigned r;
    r = $urandom_range(9);
    if (bias_high) return (r < 2) ? 16'h0 : 16'(16'hFFFF - $urandom_range(255));
    if (r < 3) return 16'h0;
    if (r == 3) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Registers change only with the pipeline drained; every phase begins a frame.
  task automatic run_phase(input int scale, input int sw, input int ow, input int pw,
                           input int oh, input int items, input int mode,
                           input bit bias_high);
    s_axis_tvalid <= 1'b0;
    @(posedge clk iff (pending == 0));
    repeat (150) @(posedge clk);
    reg_write(REG_SCALE, scale);
    reg_write(REG_SOURCE_WIDTH, sw);
    reg_write(REG_OUT_WIDTH, ow);
    reg_write(REG_PADDED_WIDTH, pw);
    reg_write(REG_OUT_HEIGHT, oh);
    idle_pct = (mode == 1) ? 82 : ((mode == 3) ? 37 : 0);
    stall_pct = (mode == 2) ? 82 : ((mode == 3) ? 37 : 0);
    for (int i = 0; i < items; i++) begin
      if (i == items / 2 && mode == 1) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk iff (pending == 0));
      end
      send_pixel(random_depth(bias_high), (i == 0) || ($urandom_range(99) < 2));
    end
  endtask

  logic [15:0] directed_px[24] = '{
    16'h0000, 16'hFFFF, 16'h5555, 16'h0000,
    16'h0001, 16'hFFFF, 16'hAAAA, 16'h0000,
    16'h0007, 16'h0007, 16'h0007, 16'h0007,
    16'h0007, 16'h0007, 16'h0007, 16'h0007,
    16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000
  };

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frame: median with extremes, a band past the frame height,
    // full padding and a second frame of empty patches.
    reg_write(REG_SCALE, 2);
    reg_write(REG_SOURCE_WIDTH, 4);
    reg_write(REG_OUT_WIDTH, 2);
    reg_write(REG_PADDED_WIDTH, 5);
    reg_write(REG_OUT_HEIGHT, 1);
    for (int i = 0; i < 24; i++) send_pixel(directed_px[i], (i == 0) || (i == 16));

    run_phase(3, 6, 2, 4, 2, 36, 1, 1'b0);
    run_phase(1, 4, 4, 4, 3, 12, 2, 1'b0);
    run_phase(8, 8, 1, 9, 1, 64, 3, 1'b1);
    run_phase(4, 9, 2, 0, 1, 36, 0, 1'b0);
    run_phase(0, 0, 4095, 4095, 4095, 10, 1, 1'b0);
    run_phase(15, 4095, 1, 4095, 0, 10, 2, 1'b0);
    run_phase(5, 11, 2, 3, 2, 40, 3, 1'b0);

    s_axis_tvalid <= 1'b0;
    @(posedge clk iff (pending == 0));
    repeat (200) @(posedge clk);

    $display("Sent %0d depth pixels over eight register settings, medians and means,",
             pixels_sent);
    $display("and checked %0d results under mixed sender and receiver stalls.",
             results_seen);
    if (errors == 0 && pending == 0) begin
      $display("tb_depth_patch_decimator_top passed");
    end else begin
      $display("tb_depth_patch_decimator_top failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/dpd_pkg.sv
src/dpd_ram.sv
src/depth_patch_decimator_top.sv
tb/dpd_checker.sv
tb/tb_depth_patch_decimator_top.sv
